// ===== sv/pixel_readout_hit_decoder_assert.svh =====
// Assertion macros used by the decoder back end (prhd_back)
`ifndef PIXEL_READOUT_HIT_DECODER_ASSERT_SVH
`define PIXEL_READOUT_HIT_DECODER_ASSERT_SVH

// implication in the same cycle, off during reset
`define PRHD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication into the next cycle, off during reset
`define PRHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// plain implication, checked during reset too
`define PRHD_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/prhd_pkg.sv =====
// ----------------------------------------------------------------------------
// prhd_pkg
// Types and constants shared by the pixel readout hit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prhd_pkg;

   localparam int STAVE_COUNT_DEF   = 16;
   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int NUM_COUNTERS      = 5;
   localparam int FIFO_DEPTH        = 2;

   localparam int CNT_BUSY_TR  = 0;
   localparam int CNT_BUSY_ERR = 1;
   localparam int CNT_TRUNC    = 2;
   localparam int CNT_CORRUPT  = 3;
   localparam int CNT_EMPTY    = 4;

   typedef enum logic [1:0] {
      KIND_HIT     = 2'd0,
      KIND_MASK    = 2'd1,
      KIND_END     = 2'd2,
      KIND_CORRUPT = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      CL_STAVE_HDR = 4'd0,
      CL_CHIP_HDR  = 4'd1,
      CL_CHIP_TRL  = 4'd2,
      CL_REGION    = 4'd3,
      CL_SHORT     = 4'd4,
      CL_LONG      = 4'd5,
      CL_STAVE_TRL = 4'd6,
      CL_TRUNC     = 4'd7,
      CL_UNKNOWN   = 4'd8
   } class_type;

   // work handed from the front end to the result sequencer, at most one per byte
   typedef struct packed {
      logic                          corrupt;
      logic                          hit;
      logic [9:0]                    addr;
      logic [3:0]                    enc;
      logic [6:0]                    map;
      logic [4:0]                    region;
      logic [11:0]                   chip;
      logic                          mask_v;
      logic [3:0]                    stave;
      logic [9:0]                    mask;
      logic                          end_v;
      logic [NUM_COUNTERS-1:0][31:0] cnt;
      logic [31:0]                   empty_end;
   } job_type;

endpackage

// ===== sv/prhd_front.sv =====
// ----------------------------------------------------------------------------
// prhd_front
// Classifies bytes, checks word order, assembles words, keeps masks/counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prhd_front #(
   parameter int STAVE_COUNT   = prhd_pkg::STAVE_COUNT_DEF,
   parameter int COUNTER_WIDTH = prhd_pkg::COUNTER_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       byte_value,
   input  logic [15:0]      bytes_left,
   output logic             push,
   output prhd_pkg::job_type job
);
   import prhd_pkg::*;

   localparam int SW = (STAVE_COUNT > 1) ? $clog2(STAVE_COUNT) : 1;

   class_type  prev_ff, prev_in, pclass_ff, pclass_in, cls;
   logic [3:0]  stave_ff, stave_in;
   logic [11:0] chip_ff, chip_in;
   logic [4:0]  region_ff, region_in;
   logic [1:0]  pbytes_ff, pbytes_in;
   logic [23:0] word_ff, word_in, word_n;
   logic        skip_ff, skip_in, hit_ff, hit_in, corr_ff, corr_in;
   logic [9:0]  mask_ff [STAVE_COUNT];
   logic        mask_we;
   logic [SW-1:0] midx;
   logic        in_range;
   logic        is_last;
   logic [NUM_COUNTERS-1:0][COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNTER_WIDTH-1:0] empty_n;

   function automatic class_type classify(input logic [7:0] b);
      if (b[7:4] == 4'ha) return CL_CHIP_HDR;
      if (b[7:4] == 4'hb) return CL_CHIP_TRL;
      if (b[7:4] == 4'he) return CL_STAVE_TRL;
      if (b[7:5] == 3'b110) return CL_REGION;
      if (b[7:6] == 2'b01) return CL_SHORT;
      if (b[7:6] == 2'b00) return CL_LONG;
      if (b == 8'hff) return CL_TRUNC;
      if (b[7:4] == 4'hf) return CL_STAVE_HDR;
      return CL_UNKNOWN;
   endfunction

   function automatic logic order_ok(input class_type p, input class_type c);
      if (c == CL_TRUNC) return 1'b1;
      unique case (p)
         CL_STAVE_HDR: return c == CL_CHIP_HDR || c == CL_STAVE_TRL;
         CL_CHIP_HDR:  return c == CL_REGION;
         CL_CHIP_TRL:  return c == CL_STAVE_TRL || c == CL_CHIP_HDR;
         CL_REGION:    return c == CL_SHORT || c == CL_LONG;
         CL_SHORT, CL_LONG:
            return c == CL_SHORT || c == CL_LONG || c == CL_REGION || c == CL_CHIP_TRL;
         CL_STAVE_TRL: return c == CL_STAVE_HDR || c == CL_CHIP_TRL;
         CL_TRUNC:     return c == CL_STAVE_TRL;
         default:      return 1'b0;
      endcase
   endfunction

   assign is_last  = bytes_left <= 16'd1;
   assign midx     = stave_ff[SW-1:0];
   assign in_range = 32'(stave_ff) < STAVE_COUNT;
   assign cls      = classify(byte_value);
   assign word_n   = {word_ff[15:0], byte_value};

   always_comb begin
      prev_in   = prev_ff;
      pclass_in = pclass_ff;
      stave_in  = stave_ff;
      chip_in   = chip_ff;
      region_in = region_ff;
      pbytes_in = pbytes_ff;
      word_in   = word_ff;
      skip_in   = skip_ff;
      hit_in    = hit_ff;
      corr_in   = corr_ff;
      cnt_in    = cnt_ff;
      mask_we   = 1'b0;
      job       = '0;
      job.region = region_ff;
      job.chip   = chip_ff;
      job.stave  = stave_ff;
      if (pbytes_ff != 2'd0) begin
         word_in   = word_n;
         pbytes_in = pbytes_ff - 2'd1;
         if (pbytes_ff == 2'd1) begin
            case (pclass_ff)
               CL_SHORT: begin
                  job.hit  = 1'b1;
                  job.addr = word_n[9:0];
                  job.enc  = word_n[13:10];
               end
               CL_LONG: begin
                  job.hit  = 1'b1;
                  job.addr = word_n[17:8];
                  job.enc  = word_n[21:18];
                  job.map  = word_n[6:0];
               end
               CL_STAVE_TRL: begin
                  if (in_range && mask_ff[midx] != word_n[19:10]) begin
                     mask_we    = 1'b1;
                     job.mask_v = 1'b1;
                     job.mask   = word_n[19:10];
                  end
               end
               default: ;
            endcase
            if (job.hit) hit_in = 1'b1;
         end
      end else if (!skip_ff) begin
         if (cls == CL_UNKNOWN || !order_ok(prev_ff, cls)) begin
            prev_in = CL_STAVE_TRL;
            cnt_in[CNT_CORRUPT] = cnt_ff[CNT_CORRUPT] + 1'b1;
            skip_in = 1'b1;
            corr_in = 1'b1;
            job.corrupt = 1'b1;
         end else begin
            prev_in   = cls;
            pclass_in = cls;
            word_in   = {16'd0, byte_value};
            unique case (cls)
               CL_STAVE_HDR: stave_in = byte_value[3:0];
               CL_CHIP_HDR: begin
                  chip_in   = {stave_ff, 8'h70} | {8'd0, byte_value[3:0]};
                  pbytes_in = 2'd1;
               end
               CL_REGION: region_in = byte_value[4:0];
               CL_SHORT:  pbytes_in = 2'd1;
               CL_LONG:   pbytes_in = 2'd2;
               CL_CHIP_TRL: begin
                  if (byte_value[3:0] == 4'd1)
                     cnt_in[CNT_BUSY_TR] = cnt_ff[CNT_BUSY_TR] + 1'b1;
                  else if (byte_value[3:0] != 4'd0)
                     cnt_in[CNT_BUSY_ERR] = cnt_ff[CNT_BUSY_ERR] + 1'b1;
               end
               CL_STAVE_TRL: begin
                  pbytes_in = 2'd2;
                  if (bytes_left < 16'd8) skip_in = 1'b1;
               end
               default: cnt_in[CNT_TRUNC] = cnt_ff[CNT_TRUNC] + 1'b1;
            endcase
         end
      end
      for (int i = 0; i < NUM_COUNTERS; i++) job.cnt[i] = 32'(cnt_in[i]);
      empty_n = cnt_in[CNT_EMPTY];
      if (is_last) begin
         if (!hit_in && !corr_in) empty_n = cnt_in[CNT_EMPTY] + 1'b1;
         cnt_in[CNT_EMPTY] = empty_n;
         job.end_v = 1'b1;
         pbytes_in = 2'd0;
         pclass_in = CL_STAVE_HDR;
         word_in   = 24'd0;
         skip_in   = 1'b0;
         hit_in    = 1'b0;
         corr_in   = 1'b0;
         stave_in  = 4'd0;
         chip_in   = 12'd0;
         region_in = 5'd0;
      end
      job.empty_end = 32'(empty_n);
      push = accept && (job.corrupt || job.hit || job.mask_v || job.end_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= CL_STAVE_TRL;
         pclass_ff <= CL_STAVE_HDR;
         stave_ff  <= 4'd0;
         chip_ff   <= 12'd0;
         region_ff <= 5'd0;
         pbytes_ff <= 2'd0;
         word_ff   <= 24'd0;
         skip_ff   <= 1'b0;
         hit_ff    <= 1'b0;
         corr_ff   <= 1'b0;
         cnt_ff    <= '0;
         for (int i = 0; i < STAVE_COUNT; i++) mask_ff[i] <= 10'd0;
      end else if (accept) begin
         prev_ff   <= prev_in;
         pclass_ff <= pclass_in;
         stave_ff  <= stave_in;
         chip_ff   <= chip_in;
         region_ff <= region_in;
         pbytes_ff <= pbytes_in;
         word_ff   <= word_in;
         skip_ff   <= skip_in;
         hit_ff    <= hit_in;
         corr_ff   <= corr_in;
         cnt_ff    <= cnt_in;
         if (mask_we) mask_ff[midx] <= word_n[19:10];
      end
   end

endmodule

// ===== sv/prhd_fifo.sv =====
// ----------------------------------------------------------------------------
// prhd_fifo
// Two-entry job queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prhd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  prhd_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output prhd_pkg::job_type head_job
);
   import prhd_pkg::*;

   job_type    mem_ff [FIFO_DEPTH];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full      = count_ff == 2'(FIFO_DEPTH);
   assign not_empty = count_ff != 2'd0;
   assign head_job  = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== sv/prhd_back.sv =====
// ----------------------------------------------------------------------------
// prhd_back
// Expands each job into result beats and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prhd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  prhd_pkg::job_type job,
   output logic             pop,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [9:0]       rsp_column,
   output logic [8:0]       rsp_row,
   output logic [11:0]      rsp_chip_ident,
   output logic [3:0]       rsp_stave,
   output logic [9:0]       rsp_chip_mask,
   output logic [31:0]      rsp_busy_transitions,
   output logic [31:0]      rsp_busy_errors,
   output logic [31:0]      rsp_truncated_events,
   output logic [31:0]      rsp_corrupt_events,
   output logic [31:0]      rsp_empty_events,
   output logic             rsp_last
);
   import prhd_pkg::*;
`include "pixel_readout_hit_decoder_assert.svh"

   job_type    cur_ff;
   logic       pc_ff, pb_ff, pk_ff, pe_ff;
   logic [6:0] pm_ff, low, pm_rest;
   logic [2:0] low_idx;
   logic [4:0] sel;
   logic       busy, load_out, last, take_new;
   logic [9:0] addr;
   logic       rsp_valid_ff;
   logic [1:0] kind_ff;
   logic [9:0] col_ff, mask_ff;
   logic [8:0] row_ff;
   logic [11:0] chip_ff;
   logic [3:0] stave_ff;
   logic [NUM_COUNTERS-1:0][31:0] cnt_ff;
   logic       last_ff;

   assign busy     = pc_ff || pb_ff || (|pm_ff) || pk_ff || pe_ff;
   assign load_out = busy && (!rsp_valid_ff || rsp_ready);
   assign low      = pm_ff & (~pm_ff + 7'd1);

   always_comb begin
      low_idx = 3'd0;
      for (int i = 0; i < 7; i++) if (low[i]) low_idx = 3'(i);
   end

   // pick the next beat: corrupt, base hit, neighbour hits, mask, event end
   assign sel[0] = pc_ff;
   assign sel[1] = !pc_ff && pb_ff;
   assign sel[2] = !pc_ff && !pb_ff && (|pm_ff);
   assign sel[3] = !pc_ff && !pb_ff && !(|pm_ff) && pk_ff;
   assign sel[4] = !pc_ff && !pb_ff && !(|pm_ff) && !pk_ff && pe_ff;
   assign pm_rest = sel[2] ? (pm_ff & ~low) : pm_ff;
   assign last = !(|pm_rest) && (sel[3] ? !pe_ff : (sel[4] ||
                 (!pk_ff && !pe_ff && (sel[2] || !(pb_ff && sel[0])))));
   assign take_new = !busy || (load_out && last);
   assign pop      = take_new && job_valid;
   assign addr = sel[2] ? (cur_ff.addr + 10'(low_idx) + 10'd1) : cur_ff.addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 1'b0;
         pb_ff <= 1'b0;
         pm_ff <= 7'd0;
         pk_ff <= 1'b0;
         pe_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_ff <= job;
            pc_ff  <= job.corrupt;
            pb_ff  <= job.hit;
            pm_ff  <= job.map;
            pk_ff  <= job.mask_v;
            pe_ff  <= job.end_v;
         end else if (load_out) begin
            pc_ff <= 1'b0;
            pb_ff <= pb_ff && !sel[1];
            pm_ff <= pm_rest;
            pk_ff <= pk_ff && !sel[3];
            pe_ff <= pe_ff && !sel[4];
         end
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         kind_ff  <= KIND_HIT;
         col_ff   <= 10'd0;
         row_ff   <= 9'd0;
         chip_ff  <= 12'd0;
         stave_ff <= 4'd0;
         mask_ff  <= 10'd0;
         cnt_ff   <= cur_ff.cnt;
         last_ff  <= last;
         if (sel[0]) kind_ff <= KIND_CORRUPT;
         if (sel[1] || sel[2]) begin
            col_ff  <= {cur_ff.region, cur_ff.enc, addr[0] ^ addr[1]};
            row_ff  <= addr[9:1];
            chip_ff <= cur_ff.chip;
         end
         if (sel[3]) begin
            kind_ff  <= KIND_MASK;
            stave_ff <= cur_ff.stave;
            mask_ff  <= cur_ff.mask;
         end
         if (sel[4]) begin
            kind_ff <= KIND_END;
            cnt_ff[CNT_EMPTY] <= cur_ff.empty_end;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_column           = col_ff;
   assign rsp_row              = row_ff;
   assign rsp_chip_ident       = chip_ff;
   assign rsp_stave            = stave_ff;
   assign rsp_chip_mask        = mask_ff;
   assign rsp_busy_transitions = cnt_ff[CNT_BUSY_TR];
   assign rsp_busy_errors      = cnt_ff[CNT_BUSY_ERR];
   assign rsp_truncated_events = cnt_ff[CNT_TRUNC];
   assign rsp_corrupt_events   = cnt_ff[CNT_CORRUPT];
   assign rsp_empty_events     = cnt_ff[CNT_EMPTY];
   assign rsp_last             = last_ff;

   `PRHD_ASSERT_IMPL(a_pop_has_job, clock, reset, pop, job_valid)
   `PRHD_ASSERT_IMPL(a_one_beat_kind, clock, reset, load_out, $onehot(sel))
   `PRHD_ASSERT_NEXT(a_stall_keeps_beat, clock, reset, rsp_valid_ff && !rsp_ready,
                     rsp_valid_ff)
   `PRHD_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset), !rsp_valid_ff)

endmodule

// ===== sv/pixel_readout_hit_decoder.sv =====
// ----------------------------------------------------------------------------
// pixel_readout_hit_decoder
// Readout byte-stream decoder: hits, stave mask changes and event counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one readout byte per beat with the bytes left in the packet
//   (1 or less marks the last byte). rsp_ channel: zero to nine result beats per byte,
//   in stream order; rsp_last marks the final beat caused by one byte.
//   The front end takes one byte per cycle while the two-entry job queue has
//   room, classifies it and updates order state, masks and counters at once.
//   The back end sends one result beat per cycle from its output register while rsp_ready is high.
//   Path: a byte's job is queued, loaded into the back end's job register, then expanded into the output register.
//   Throughput: one byte per cycle while the queue has room, one result per
//   cycle while the receiver is ready; a long data word (3 bytes) gives up
//   to 8 hits, so in dense hit data the back end sets the sustained rate.
//   Reset: all order state, masks and counters clear; nothing is in flight.
//   Receiver stall: hold the current result; the queue fills and req_ready
//   drops once it holds two jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_readout_hit_decoder #(
   parameter int STAVE_COUNT   = prhd_pkg::STAVE_COUNT_DEF,
   parameter int COUNTER_WIDTH = prhd_pkg::COUNTER_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_bytes_left,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_column,
   output logic [8:0]  rsp_row,
   output logic [11:0] rsp_chip_ident,
   output logic [3:0]  rsp_stave,
   output logic [9:0]  rsp_chip_mask,
   output logic [31:0] rsp_busy_transitions,
   output logic [31:0] rsp_busy_errors,
   output logic [31:0] rsp_truncated_events,
   output logic [31:0] rsp_corrupt_events,
   output logic [31:0] rsp_empty_events,
   output logic        rsp_last
);
   import prhd_pkg::*;

   job_type push_job, head_job;
   logic    accept, push, pop, full, not_empty;

   // take a byte whenever the queue can hold the job it may make
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   prhd_front #(
      .STAVE_COUNT  (STAVE_COUNT),
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_value(req_byte_value),
      .bytes_left(req_bytes_left),
      .push      (push),
      .job       (push_job)
   );

   prhd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .not_empty(not_empty),
      .head_job (head_job)
   );

   prhd_back u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (not_empty),
      .job                 (head_job),
      .pop                 (pop),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_column          (rsp_column),
      .rsp_row             (rsp_row),
      .rsp_chip_ident      (rsp_chip_ident),
      .rsp_stave           (rsp_stave),
      .rsp_chip_mask       (rsp_chip_mask),
      .rsp_busy_transitions(rsp_busy_transitions),
      .rsp_busy_errors     (rsp_busy_errors),
      .rsp_truncated_events(rsp_truncated_events),
      .rsp_corrupt_events  (rsp_corrupt_events),
      .rsp_empty_events    (rsp_empty_events),
      .rsp_last            (rsp_last)
   );

endmodule
